@@ design/grr_pkg.sv @@
// ----------------------------------------------------------------------------
// grr_pkg
// Shared constants and controller/datapath handshake types for the group
// reversal reorderer.
// ----------------------------------------------------------------------------
package grr_pkg;

   // default depth of the group buffer
   localparam int GROUP_MAX_DEF = 16;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int GSIZE_W = 5;

   // group_size after reset
   localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(1);

   // controller -> datapath commands
   typedef struct packed {
      logic store;   // write the accepted request into the group buffer
      logic step;    // read one buffered entry into the response register
   } grr_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic flush;   // the request being offered closes a group
      logic rem_one; // one entry left to drain
   } grr_status_type;

endpackage

@@ design/grr_req_if.sv @@
// ----------------------------------------------------------------------------
// grr_req_if
// Valid/ready channel carrying one request item of the reorderer.
// ----------------------------------------------------------------------------
interface grr_req_if
   import grr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] item_value;
   logic                      item_last;

   modport source (output valid, output item_value, output item_last, input ready);
   modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

@@ design/grr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// grr_rsp_if
// Valid/ready channel carrying one reordered response item.
// ----------------------------------------------------------------------------
interface grr_rsp_if
   import grr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] out_value;
   logic                      out_last;

   modport source (output valid, output out_value, output out_last, input ready);
   modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

@@ design/grr_datapath.sv @@
// ----------------------------------------------------------------------------
// grr_datapath
// Group buffer, fill count, group size register, drain pointer and the
// response output register.
// ----------------------------------------------------------------------------
module grr_datapath
   import grr_pkg::*;
#(
   parameter int GROUP_MAX = GROUP_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [GSIZE_W-1:0]        csr_wr_data,
   input  logic signed [VALUE_W-1:0] item_value,
   input  logic                      item_last,
   input  grr_cmd_type               cmd,
   output grr_status_type            st,
   output logic signed [VALUE_W-1:0] out_value,
   output logic                      out_last
);
   localparam int CNT_W = $clog2(GROUP_MAX + 1);
   localparam int IDX_W = $clog2(GROUP_MAX);
   localparam int EW    = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

   logic signed [VALUE_W-1:0] mem [GROUP_MAX];

   logic [GSIZE_W-1:0]        gsize_ff, gsize_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [IDX_W-1:0]          rptr_ff, rptr_in;
   logic                      rev_ff, rev_in;
   logic                      seq_last_ff, seq_last_in;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic                      out_last_ff;

   logic [EW-1:0]    gs_ext;
   logic [EW-1:0]    eff;
   logic [CNT_W-1:0] fill_next;
   logic             full_hit;

   // effective group size, clamped to 1..GROUP_MAX
   always_comb begin
      gs_ext = EW'(gsize_ff);
      if (gs_ext == '0) begin
         eff = EW'(1);
      end else if (gs_ext > EW'(GROUP_MAX)) begin
         eff = EW'(GROUP_MAX);
      end else begin
         eff = gs_ext;
      end
   end

   // group close decision for the offered request
   assign fill_next   = fill_ff + CNT_W'(1);
   assign full_hit    = EW'(fill_next) >= eff;
   assign st.flush    = full_hit | item_last;
   assign st.rem_one  = (rem_ff == CNT_W'(1));

   // next-state logic
   always_comb begin
      gsize_in    = csr_wr_en ? csr_wr_data : gsize_ff;
      fill_in     = fill_ff;
      rem_in      = rem_ff;
      rptr_in     = rptr_ff;
      rev_in      = rev_ff;
      seq_last_in = seq_last_ff;
      if (cmd.store) begin
         fill_in = st.flush ? '0 : fill_next;
         if (st.flush) begin
            rem_in      = fill_next;
            rev_in      = full_hit;
            seq_last_in = item_last;
            // reversed drain starts at the newest entry
            rptr_in     = full_hit ? fill_ff[IDX_W-1:0] : '0;
         end
      end else if (cmd.step) begin
         rem_in  = rem_ff - CNT_W'(1);
         rptr_in = rev_ff ? rptr_ff - IDX_W'(1) : rptr_ff + IDX_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= GSIZE_RESET;
         fill_ff  <= '0;
         rem_ff   <= '0;
      end else begin
         gsize_ff <= gsize_in;
         fill_ff  <= fill_in;
         rem_ff   <= rem_in;
      end
   end

   // drain pointer and sequence flags
   always_ff @(posedge clock) begin
      rptr_ff     <= rptr_in;
      rev_ff      <= rev_in;
      seq_last_ff <= seq_last_in;
   end

   // group buffer: write on store, registered read on step
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[fill_ff[IDX_W-1:0]] <= item_value;
      end
      if (cmd.step) begin
         out_value_ff <= mem[rptr_ff];
         out_last_ff  <= seq_last_ff & st.rem_one;
      end
   end

   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(GROUP_MAX))
      else $error("fill count reached buffer depth");

   a_flush_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.store && st.flush |=> rem_ff != '0 && fill_ff == '0)
      else $error("group flush did not load drain count");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.step && st.rem_one && seq_last_ff |=> out_last_ff)
      else $error("final response of a sequence lost its last flag");
`endif
endmodule

@@ design/grr_ctrl.sv @@
// ----------------------------------------------------------------------------
// grr_ctrl
// Controller: accepts requests while collecting, then steps the drain of a
// closed group into the response register under receiver backpressure.
// ----------------------------------------------------------------------------
module grr_ctrl
   import grr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  grr_status_type st,
   output grr_cmd_type    cmd
);
   typedef enum logic [0:0] {
      S_COLLECT,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // handshake and command decode
   always_comb begin
      req_ready = (state_ff == S_COLLECT);
      cmd.store = req_ready & req_valid;
      cmd.step  = (state_ff == S_DRAIN) & (~rsp_valid_ff | rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_COLLECT: begin
            if (cmd.store && st.flush) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (cmd.step && st.rem_one) state_in = S_COLLECT;
         end
         default: state_in = S_COLLECT;
      endcase
      // response register fills on a step, empties when taken
      rsp_valid_in = cmd.step | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.store && st.flush |=> state_ff == S_DRAIN)
      else $error("closed group did not start draining");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> rsp_valid_ff)
      else $error("drain step did not present a response");
`endif
endmodule

@@ design/group_reversal_reorderer.sv @@
// ----------------------------------------------------------------------------
// group_reversal_reorderer
// Streams items through a group buffer and emits full groups reversed.
//
// Request channel req: item_value and item_last, valid/ready. Requests are
// collected one per cycle, except while a group drains, into a buffer of
// GROUP_MAX entries. When the held count reaches the effective group size
// (group_size clamped to 1..GROUP_MAX) the group is emitted newest first;
// when item_last arrives before that, the partial group is emitted oldest
// first. out_last marks the final response of a sequence. Response channel
// rsp: out_value and out_last, valid/ready. csr_wr_en/csr_wr_data write
// group_size (reset value 1); write only when idle. A request that does not
// close a group is only stored. One that closes a group moves the controller
// to its drain state, whose steps load the response register, one response
// per cycle while the receiver takes it; req_ready stays low while the single
// buffer read port drains the group.
// A stalled receiver holds the response register and pauses the drain.
// Reset is synchronous: the buffer is emptied and group_size returns to 1.
// ----------------------------------------------------------------------------
module group_reversal_reorderer
   import grr_pkg::*;
#(
   parameter int GROUP_MAX = GROUP_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   grr_req_if.sink            req,
   grr_rsp_if.source          rsp,
   input  logic               csr_wr_en,
   input  logic [GSIZE_W-1:0] csr_wr_data
);
   grr_cmd_type    cmd;
   grr_status_type st;

   // controller
   grr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // datapath
   grr_datapath #(
      .GROUP_MAX (GROUP_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_value  (req.item_value),
      .item_last   (req.item_last),
      .cmd         (cmd),
      .st          (st),
      .out_value   (rsp.out_value),
      .out_last    (rsp.out_last)
   );
endmodule

@@ tb/sv/grr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_checker
// Watches the request, response and register-write traffic of the group
// reversal reorderer. It keeps its own group buffer, fill count and group
// size, builds the responses that each accepted request should produce, and
// compares every accepted response field by field with the oldest one due.
// ----------------------------------------------------------------------------
module grr_checker
   import grr_pkg::*;
#(
   parameter int GROUP_MAX = GROUP_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   grr_req_if                 req,
   grr_rsp_if                 rsp,
   input  logic               csr_wr_en,
   input  logic [GSIZE_W-1:0] csr_wr_data,
   output int                 pending_count,
   output int                 error_count
);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_word_type;

   logic [VALUE_W-1:0] held_values [GROUP_MAX];
   int unsigned        held_count;
   logic [GSIZE_W-1:0] group_size;
   rsp_word_type       due_q [$];
   rsp_word_type       want;

   // store one request; queue the group it closes, if any
   task automatic collect_request(logic [VALUE_W-1:0] value, logic last);
      int unsigned  limit;
      int unsigned  n;
      rsp_word_type word;
      limit = (group_size < 1) ? 1 : ((group_size > GROUP_MAX) ? GROUP_MAX : group_size);
      if (held_count >= GROUP_MAX) held_count = 0;
      held_values[held_count] = value;
      held_count++;
      n = held_count;
      if (n >= limit) begin
         // full (or over-full after a size drop): newest first
         for (int unsigned i = 0; i < n; i++) begin
            word.value = held_values[n - 1 - i];
            word.last  = last && (i == n - 1);
            due_q.push_back(word);
         end
         held_count = 0;
      end else if (last) begin
         // sequence ends short of a group: original order
         for (int unsigned i = 0; i < n; i++) begin
            word.value = held_values[i];
            word.last  = (i == n - 1);
            due_q.push_back(word);
         end
         held_count = 0;
      end
   endtask

   // sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         group_size = GSIZE_RESET;
         due_q.delete();
      end else begin
         if (csr_wr_en) group_size = csr_wr_data;
         if (req.valid && req.ready) collect_request(req.item_value, req.item_last);
         if (rsp.valid && rsp.ready) begin
            if (due_q.size() == 0) begin
               error_count++;
               $display("%0t: response with none due: expected nothing, got value %h last %b",
                        $time, rsp.out_value, rsp.out_last);
            end else begin
               want = due_q.pop_front();
               if (rsp.out_value !== want.value) begin
                  error_count++;
                  $display("%0t: out_value expected %h, got %h",
                           $time, want.value, rsp.out_value);
               end
               if (rsp.out_last !== want.last) begin
                  error_count++;
                  $display("%0t: out_last expected %b, got %b",
                           $time, want.last, rsp.out_last);
               end
            end
         end
      end
      pending_count = due_q.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the group reversal reorderer with directed corner cases (pass-through
// sizes, full groups, partial groups, a size drop mid-group), then with random
// sequences over many group sizes, random request gaps and response stalls.
// Checking is done by grr_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import grr_pkg::*;

   localparam int          SETTLE_CYCLES = 4;
   localparam int          TARGET_ITEMS  = 220;
   localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [GSIZE_W-1:0] csr_wr_data;
   int                 pending_count;
   int                 error_count;
   int unsigned        gap_max;
   int unsigned        stall_max;
   int unsigned        items_sent;
   int unsigned        phase;
   int unsigned        limit;
   logic [GSIZE_W-1:0] size;

   logic [VALUE_W-1:0] corner_values [4] = '{32'h0000_0000, 32'h7FFF_FFFF,
                                             32'h8000_0000, 32'hFFFF_FFFF};

   grr_req_if req_if();
   grr_rsp_if rsp_if();

   group_reversal_reorderer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   grr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop
   initial begin
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // send one request after a random gap
   task automatic send_request(logic [VALUE_W-1:0] value, logic last);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.item_value <= value;
      req_if.item_last  <= last;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // hold off until every due response is in and the block is quiet
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_group_size(logic [GSIZE_W-1:0] new_size);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= new_size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random values, some corners; last flag on the final one if asked
   task automatic send_sequence(int unsigned len, bit with_last);
      logic [VALUE_W-1:0] value;
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0) value = corner_values[$urandom_range(0, 3)];
         else value = $urandom();
         send_request(value, with_last && (i == len - 1));
      end
   endtask

   // response side: random stall before each response
   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // stimulus
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.item_value <= '0;
      req_if.item_last  <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      gap_max            = 3;
      stall_max          = 3;
      items_sent         = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // size 1 after reset: straight through, each with its own last flag
      send_request(32'h7FFF_FFFF, 1'b0);
      send_request(32'h8000_0000, 1'b1);
      // size 0 behaves as 1
      write_group_size(GSIZE_W'(0));
      send_request(32'hFFFF_FFFF, 1'b0);
      send_request(32'h0000_0000, 1'b1);
      // full group closed by the last request, then a short tail in order
      write_group_size(GSIZE_W'(4));
      for (int unsigned i = 1; i <= 6; i++) send_request(i, (i == 4) || (i == 6));
      // two held at size 3, then size drops to 2: all three come out reversed
      write_group_size(GSIZE_W'(3));
      send_request(32'd7, 1'b0);
      send_request(32'd8, 1'b0);
      write_group_size(GSIZE_W'(2));
      send_request(32'd9, 1'b0);
      send_request(32'd10, 1'b1);

      // random phases, extremes of the size first
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         case (phase)
            0:       size = GSIZE_W'(16);
            1:       size = GSIZE_W'(31);
            2:       size = GSIZE_W'(17);
            3:       size = GSIZE_W'(0);
            4:       size = GSIZE_W'(1);
            default: size = ($urandom_range(0, 3) == 0) ? GSIZE_W'($urandom_range(0, 31))
                                                        : GSIZE_W'($urandom_range(2, 6));
         endcase
         gap_max   = $urandom_range(0, 1) ? 7 : 0;
         stall_max = $urandom_range(0, 1) ? 7 : 0;
         write_group_size(size);
         limit = (size < 1) ? 1 : ((size > GROUP_MAX_DEF) ? GROUP_MAX_DEF : size);
         repeat ($urandom_range(1, 3)) send_sequence($urandom_range(1, 2 * limit + 1), 1'b1);
         // sometimes leave a group half filled across the next size change
         if ($urandom_range(0, 4) == 0) send_sequence($urandom_range(1, limit), 1'b0);
         phase++;
      end

      wait_drained();
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
